// ===== rtl/core/triangular_distribution_eval_assert.svh =====
// Assertion macros for the triangular distribution evaluator.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef TRIANGULAR_DISTRIBUTION_EVAL_ASSERT_SVH
`define TRIANGULAR_DISTRIBUTION_EVAL_ASSERT_SVH

// Same-cycle implication
`define TDE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TDE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tde_pkg.sv =====
// ----------------------------------------------------------------------------
// tde_pkg
// Shared types and constants of the triangular distribution evaluator.
// ----------------------------------------------------------------------------
package tde_pkg;

    localparam int VAL_W     = 24;
    localparam int CMD_W     = 2;
    localparam int ST_W      = 2;
    localparam int CFG_IDX_W = 2;
    localparam int DENS_FRAC = 20;

    localparam logic [VAL_W-1:0] MASK24   = {VAL_W{1'b1}};
    localparam logic [VAL_W-1:0] LOW_RST  = 24'd20480;
    localparam logic [VAL_W-1:0] HIGH_RST = 24'd327680;
    localparam logic [VAL_W-1:0] MODE_RST = 24'd186778;

    localparam logic [CFG_IDX_W-1:0] REG_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_DENSITY = 2'd0,
        CMD_CUMUL   = 2'd1,
        CMD_INVERSE = 2'd2,
        CMD_UNUSED  = 2'd3
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_PROB   = 2'd1,
        ST_BOUNDS = 2'd2,
        ST_SAT    = 2'd3
    } t_status;

    // Per-item flags that travel down the pipeline
    typedef struct packed {
        t_cmd cmd;
        logic bad;
        logic outside;
        logic z_le_a;
        logic z_ge_b;
        logic lt;
        logic peak;
        logic p_over;
        logic p_zero;
        logic p_full;
        logic inv_lo;
    } t_ctl;

endpackage

// ===== rtl/core/tde_cmd_if.sv =====
// ----------------------------------------------------------------------------
// tde_cmd_if
// Command channel: one command word per handshake.
// ----------------------------------------------------------------------------
interface tde_cmd_if;
    import tde_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [VAL_W-1:0] operand_value;

    modport source (output valid, output command, output operand_value, input ready);
    modport sink   (input valid, input command, input operand_value, output ready);
endinterface

// ===== rtl/core/tde_res_if.sv =====
// ----------------------------------------------------------------------------
// tde_res_if
// Result channel: one result word per handshake.
// ----------------------------------------------------------------------------
interface tde_res_if;
    import tde_pkg::*;

    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] result_value;
    logic [ST_W-1:0]  status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface

// ===== rtl/core/triangular_distribution_eval.sv =====
// ----------------------------------------------------------------------------
// triangular_distribution_eval
// Density, cumulative and inverse cumulative of a triangular distribution.
// ----------------------------------------------------------------------------
// Usage:
//   Bounds and mode are written through i_cfg_we / i_cfg_idx / i_cfg_data
//   (index 0 low, 1 high, 2 mode) while no word is in flight.
//   Command words enter on i_cmd (valid/ready), results leave on o_res.
//   A result passes the registers of four setup stages (differences,
//   products, split multiply, alignment), then 25 stages that each retire
//   one quotient bit of the divider and one root bit of the square root
//   side by side, and then the output register.
//   Throughput: one word per cycle while o_res.ready does not stall the
//   pipeline, set by the fully pipelined divider and root stages.
//   Reset clears the valid bits of all stages and loads the default bounds and mode.
//   When the receiver holds o_res.ready low with a result waiting, the whole
//   pipeline freezes and i_cmd.ready drops; bubbles in flight are kept, and
//   nothing is lost or repeated.
// ----------------------------------------------------------------------------
module triangular_distribution_eval #(
    parameter int POINT_FRAC_BITS = 12,
    parameter int PROB_FRAC_BITS  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tde_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tde_pkg::VAL_W-1:0]      i_cfg_data,
    tde_cmd_if.sink                        i_cmd,
    tde_res_if.source                      o_res
);
    import tde_pkg::*;

    localparam int DSH   = POINT_FRAC_BITS + DENS_FRAC + 1;
    localparam int XW_D  = VAL_W + DSH;
    localparam int XW_C  = 2 * VAL_W + PROB_FRAC_BITS;
    localparam int NW    = ((XW_D > XW_C) ? XW_D : XW_C) + 2;
    localparam int DENW  = 2 * VAL_W;
    localparam int DW    = DENW + 1;
    localparam int QW    = VAL_W + 1;
    localparam int NSTEP = QW;
    localparam int SW    = 2 * QW;
    localparam int RTW   = QW;
    localparam int SRW   = RTW + 3;
    localparam int PW    = VAL_W + 1;
    localparam int YW    = 3 * VAL_W;
    localparam int RW    = VAL_W + 2;
    localparam logic [PW-1:0] ONE = {{(PW-1){1'b0}}, 1'b1} << PROB_FRAC_BITS;

    // ---------------- configuration ----------------
    logic [VAL_W-1:0] r_low, r_high, r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= LOW_RST;
            r_high <= HIGH_RST;
            r_mode <= MODE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LOW:  r_low  <= i_cfg_data;
                REG_HIGH: r_high <= i_cfg_data;
                REG_MODE: r_mode <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic    r_out_valid;
    logic    en;
    assign en          = !r_out_valid || o_res.ready;
    assign i_cmd.ready = en;

    // ---------------- stage 1: differences and flags ----------------
    logic [VAL_W-1:0] c1_z;
    t_ctl             c1_ctl;
    logic [VAL_W-1:0] c1_d;
    logic             r1_v;
    t_ctl             r1_ctl;
    logic [VAL_W-1:0] r1_ba, r1_ma, r1_bm, r1_d;
    logic [PW-1:0]    r1_p;

    always_comb begin
        c1_z           = i_cmd.operand_value;
        c1_ctl.cmd     = t_cmd'(i_cmd.command);
        c1_ctl.bad     = (r_low >= r_high) || (r_mode < r_low) || (r_mode > r_high);
        c1_ctl.outside = (c1_z < r_low) || (c1_z > r_high);
        c1_ctl.z_le_a  = (c1_z <= r_low);
        c1_ctl.z_ge_b  = (c1_z >= r_high);
        c1_ctl.lt      = (c1_z < r_mode);
        c1_ctl.peak    = (c1_z == r_mode);
        c1_ctl.p_over  = ({1'b0, c1_z} > ONE);
        c1_ctl.p_zero  = (c1_z == '0);
        c1_ctl.p_full  = ({1'b0, c1_z} >= ONE);
        c1_ctl.inv_lo  = 1'b0;
        c1_d           = c1_ctl.lt ? (c1_z - r_low) : (r_high - c1_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ctl <= c1_ctl;
            r1_ba  <= r_high - r_low;
            r1_ma  <= r_mode - r_low;
            r1_bm  <= r_high - r_mode;
            r1_d   <= c1_d;
            r1_p   <= {1'b0, c1_z};
        end
    end

    // ---------------- stage 2: products ----------------
    logic [PW-1:0]    c2_mul_a;
    logic [DW-1:0]    c2_prod;
    logic [DENW-1:0]  c2_sq;
    logic             r2_v;
    t_ctl             r2_ctl;
    logic [VAL_W-1:0] r2_ba, r2_ma, r2_bm, r2_d;
    logic [DW-1:0]    r2_prod;
    logic [DENW-1:0]  r2_sq;

    assign c2_mul_a = (r1_ctl.cmd == CMD_INVERSE) ? r1_p
                    : {1'b0, (r1_ctl.lt ? r1_ma : r1_bm)};
    assign c2_prod  = DW'(c2_mul_a) * DW'(r1_ba);
    assign c2_sq    = DENW'(r1_d) * DENW'(r1_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ctl  <= r1_ctl;
            r2_ba   <= r1_ba;
            r2_ma   <= r1_ma;
            r2_bm   <= r1_bm;
            r2_d    <= r1_d;
            r2_prod <= c2_prod;
            r2_sq   <= c2_sq;
        end
    end

    // ---------------- stage 3: branch pick, split multiply, dividend ----------------
    t_ctl             c3_ctl;
    logic [DENW-1:0]  c3_x;
    logic [VAL_W-1:0] c3_g;
    logic [NW-1:0]    c3_xn;
    logic [DENW-1:0]  c3_den;
    logic             r3_v;
    t_ctl             r3_ctl;
    logic [DENW-1:0]  r3_hi, r3_lo;
    logic [NW-1:0]    r3_n;
    logic [DW-1:0]    r3_d;

    always_comb begin
        c3_ctl        = r2_ctl;
        c3_ctl.inv_lo = r2_prod < (DW'(r2_ma) << PROB_FRAC_BITS);
        c3_x          = c3_ctl.inv_lo ? r2_prod[DENW-1:0]
                      : (DENW'(r2_ba) << PROB_FRAC_BITS) - r2_prod[DENW-1:0];
        c3_g          = c3_ctl.inv_lo ? r2_ma : r2_bm;
        if (r2_ctl.cmd == CMD_CUMUL) begin
            c3_xn  = NW'(r2_sq) << PROB_FRAC_BITS;
            c3_den = r2_prod[DENW-1:0];
        end else if (r2_ctl.peak) begin
            c3_xn  = NW'(1) << DSH;
            c3_den = DENW'(r2_ba);
        end else begin
            c3_xn  = NW'(r2_d) << DSH;
            c3_den = r2_prod[DENW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_ctl <= c3_ctl;
            r3_hi  <= DENW'(c3_x[DENW-1:VAL_W]) * DENW'(c3_g);
            r3_lo  <= DENW'(c3_x[VAL_W-1:0]) * DENW'(c3_g);
            // round half up: (2x + den) / (2 den)
            r3_n   <= (c3_xn << 1) + NW'(c3_den);
            r3_d   <= {c3_den, 1'b0};
        end
    end

    // ---------------- stage 4: align root operand, divider overflow ----------------
    logic [YW-1:0]   c4_y;
    logic [YW+1:0]   c4_y2;
    logic [NW-1:0]   c4_top;

    logic            s_v    [0:NSTEP];
    t_ctl            s_ctl  [0:NSTEP];
    logic [DW-1:0]   s_den  [0:NSTEP];
    logic [DW-1:0]   s_rem  [0:NSTEP];
    logic [QW-1:0]   s_nb   [0:NSTEP];
    logic [QW-1:0]   s_q    [0:NSTEP];
    logic            s_ovf  [0:NSTEP];
    logic [SW-1:0]   s_w    [0:NSTEP];
    logic [SRW-1:0]  s_srem [0:NSTEP];
    logic [RTW-1:0]  s_root [0:NSTEP];

    assign c4_y   = (YW'(r3_hi) << VAL_W) + YW'(r3_lo);
    assign c4_y2  = {c4_y, 2'b00} >> PROB_FRAC_BITS;
    assign c4_top = r3_n >> QW;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_v[0] <= 1'b0;
        end else if (en) begin
            s_v[0] <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            s_ctl[0]  <= r3_ctl;
            s_den[0]  <= r3_d;
            s_rem[0]  <= c4_top[DW-1:0];
            s_nb[0]   <= r3_n[QW-1:0];
            s_q[0]    <= '0;
            s_ovf[0]  <= c4_top >= NW'(r3_d);
            s_w[0]    <= c4_y2[SW-1:0];
            s_srem[0] <= '0;
            s_root[0] <= '0;
        end
    end

    // ---------------- one quotient bit and one root bit per stage ----------------
    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        logic [DW:0]    c_r2;
        logic           c_ge;
        logic [SRW-1:0] c_sr2;
        logic [SRW-1:0] c_trial;
        logic           c_sge;

        assign c_r2    = {s_rem[k], s_nb[k][QW-1]};
        assign c_ge    = c_r2 >= {1'b0, s_den[k]};
        assign c_sr2   = {s_srem[k][SRW-3:0], s_w[k][SW-1:SW-2]};
        assign c_trial = (SRW'(s_root[k]) << 2) | SRW'(1);
        assign c_sge   = c_sr2 >= c_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                s_v[k+1] <= 1'b0;
            end else if (en) begin
                s_v[k+1] <= s_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                s_ctl[k+1]  <= s_ctl[k];
                s_den[k+1]  <= s_den[k];
                s_rem[k+1]  <= c_ge ? DW'(c_r2 - {1'b0, s_den[k]}) : c_r2[DW-1:0];
                s_nb[k+1]   <= s_nb[k] << 1;
                s_q[k+1]    <= {s_q[k][QW-2:0], c_ge};
                s_ovf[k+1]  <= s_ovf[k];
                s_w[k+1]    <= s_w[k] << 2;
                s_srem[k+1] <= c_sge ? (c_sr2 - c_trial) : c_sr2;
                s_root[k+1] <= {s_root[k][RTW-2:0], c_sge};
            end
        end
    end

    // ---------------- output stage ----------------
    t_ctl             c5_ctl;
    logic [QW-1:0]    c5_q;
    logic [RTW-1:0]   c5_s;
    logic [RW-1:0]    c5_res;
    logic [RW-1:0]    c5_v;
    t_status          c5_st;
    logic [VAL_W-1:0] r_res;
    t_status          r_st;

    always_comb begin
        c5_ctl = s_ctl[NSTEP];
        c5_q   = s_q[NSTEP];
        c5_s   = RTW'((RW'(s_root[NSTEP]) + RW'(1)) >> 1);
        c5_res = '0;
        c5_v   = '0;
        c5_st  = ST_OK;
        case (c5_ctl.cmd)
            CMD_DENSITY: begin
                if (c5_ctl.outside) c5_res = '0;
                else if (s_ovf[NSTEP]) c5_res = '1;
                else c5_res = RW'(c5_q);
            end
            CMD_CUMUL: begin
                if (c5_ctl.z_le_a) begin
                    c5_res = '0;
                end else if (c5_ctl.z_ge_b) begin
                    c5_res = RW'(ONE);
                end else if (c5_ctl.lt) begin
                    c5_res = s_ovf[NSTEP] ? '1 : RW'(c5_q);
                end else begin
                    // clip to one, then take the complement
                    c5_v   = (s_ovf[NSTEP] || (RW'(c5_q) > RW'(ONE))) ? RW'(ONE) : RW'(c5_q);
                    c5_res = RW'(ONE) - c5_v;
                end
            end
            CMD_INVERSE: begin
                if (c5_ctl.p_over) begin
                    c5_st = ST_PROB;
                end else if (c5_ctl.p_zero) begin
                    c5_res = RW'(r_low);
                end else if (c5_ctl.p_full) begin
                    c5_res = RW'(r_high);
                end else if (c5_ctl.inv_lo) begin
                    c5_res = RW'(r_low) + RW'(c5_s);
                end else if (RW'(c5_s) > RW'(r_high)) begin
                    c5_res = '0;
                end else begin
                    c5_res = RW'(r_high) - RW'(c5_s);
                end
            end
            default: ;
        endcase
        if (c5_ctl.cmd != CMD_UNUSED && c5_ctl.bad) begin
            c5_res = '0;
            c5_st  = ST_BOUNDS;
        end
        if (c5_res > RW'(MASK24)) begin
            c5_res = RW'(MASK24);
            c5_st  = ST_SAT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= s_v[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= c5_res[VAL_W-1:0];
            r_st  <= c5_st;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.result_value = r_res;
    assign o_res.status       = r_st;

    // ---------------- assertions ----------------
`include "triangular_distribution_eval_assert.svh"

    `TDE_ASSERT_NOW(a_sat_full, r_out_valid && (r_st == ST_SAT), r_res == MASK24, "saturated word below full scale")
    `TDE_ASSERT_NOW(a_err_zero, r_out_valid && ((r_st == ST_PROB) || (r_st == ST_BOUNDS)), r_res == '0, "error word carries a value")
    `TDE_ASSERT_NEXT(a_drain, en && s_v[NSTEP], r_out_valid, "last stage word not moved to output")

endmodule
